/* src/scl_pkg.sv */
// Shared constants and the quarter-wave sine table for the sine/cosine lookup.
// No dependencies; used by scl_interp and sine_cosine_lut_interp_top.
package scl_pkg;

    // Phase step that turns a sine lookup into a cosine lookup (90 degrees).
    localparam logic [15:0] COS_OFFSET = 16'h4000;
    // Magnitude at the peak of the quarter wave, where the upper index wraps.
    localparam logic [15:0] PEAK_MAG = 16'h7FFF;
    // Rounding bias added before the interpolation step is scaled down.
    localparam logic [15:0] ROUND_BIAS = 16'h0080;
    // Offset span of one table interval, used to mirror the offset.
    localparam logic [6:0] OFFSET_SPAN = 7'd64;

    // Quarter-wave sine table, Q15, 256 entries from 0 up to just below 90 degrees.
    localparam logic [15:0] QUARTER_ROM [256] = '{
        16'h0000, 16'h00C9, 16'h0192, 16'h025B, 16'h0324, 16'h03ED, 16'h04B6, 16'h057F,
        16'h0648, 16'h0711, 16'h07D9, 16'h08A2, 16'h096B, 16'h0A33, 16'h0AFB, 16'h0BC4,
        16'h0C8C, 16'h0D54, 16'h0E1C, 16'h0EE4, 16'h0FAB, 16'h1073, 16'h113A, 16'h1201,
        16'h12C8, 16'h138F, 16'h1455, 16'h151C, 16'h15E2, 16'h16A8, 16'h176E, 16'h1833,
        16'h18F9, 16'h19BE, 16'h1A83, 16'h1B47, 16'h1C0C, 16'h1CD0, 16'h1D93, 16'h1E57,
        16'h1F1A, 16'h1FDD, 16'h209F, 16'h2162, 16'h2224, 16'h22E5, 16'h23A7, 16'h2467,
        16'h2528, 16'h25E8, 16'h26A8, 16'h2768, 16'h2827, 16'h28E5, 16'h29A4, 16'h2A62,
        16'h2B1F, 16'h2BDC, 16'h2C99, 16'h2D55, 16'h2E11, 16'h2ECC, 16'h2F87, 16'h3042,
        16'h30FC, 16'h31B5, 16'h326E, 16'h3327, 16'h33DF, 16'h3497, 16'h354E, 16'h3604,
        16'h36BA, 16'h3770, 16'h3825, 16'h38D9, 16'h398D, 16'h3A40, 16'h3AF3, 16'h3BA5,
        16'h3C57, 16'h3D08, 16'h3DB8, 16'h3E68, 16'h3F17, 16'h3FC6, 16'h4074, 16'h4121,
        16'h41CE, 16'h427A, 16'h4326, 16'h43D1, 16'h447B, 16'h4524, 16'h45CD, 16'h4675,
        16'h471D, 16'h47C4, 16'h486A, 16'h490F, 16'h49B4, 16'h4A58, 16'h4AFB, 16'h4B9E,
        16'h4C40, 16'h4CE1, 16'h4D81, 16'h4E21, 16'h4EC0, 16'h4F5E, 16'h4FFB, 16'h5098,
        16'h5134, 16'h51CF, 16'h5269, 16'h5303, 16'h539B, 16'h5433, 16'h54CA, 16'h5560,
        16'h55F6, 16'h568A, 16'h571E, 16'h57B1, 16'h5843, 16'h58D4, 16'h5964, 16'h59F4,
        16'h5A82, 16'h5B10, 16'h5B9D, 16'h5C29, 16'h5CB4, 16'h5D3E, 16'h5DC8, 16'h5E50,
        16'h5ED7, 16'h5F5E, 16'h5FE4, 16'h6068, 16'h60EC, 16'h616F, 16'h61F1, 16'h6272,
        16'h62F2, 16'h6371, 16'h63EF, 16'h646C, 16'h64E9, 16'h6564, 16'h65DE, 16'h6657,
        16'h66D0, 16'h6747, 16'h67BD, 16'h6832, 16'h68A7, 16'h691A, 16'h698C, 16'h69FD,
        16'h6A6E, 16'h6ADD, 16'h6B4B, 16'h6BB8, 16'h6C24, 16'h6C8F, 16'h6CF9, 16'h6D62,
        16'h6DCA, 16'h6E31, 16'h6E97, 16'h6EFB, 16'h6F5F, 16'h6FC2, 16'h7023, 16'h7083,
        16'h70E3, 16'h7141, 16'h719E, 16'h71FA, 16'h7255, 16'h72AF, 16'h7308, 16'h735F,
        16'h73B6, 16'h740B, 16'h7460, 16'h74B3, 16'h7505, 16'h7556, 16'h75A6, 16'h75F4,
        16'h7642, 16'h768E, 16'h76D9, 16'h7723, 16'h776C, 16'h77B4, 16'h77FB, 16'h7840,
        16'h7885, 16'h78C8, 16'h790A, 16'h794A, 16'h798A, 16'h79C9, 16'h7A06, 16'h7A42,
        16'h7A7D, 16'h7AB7, 16'h7AEF, 16'h7B27, 16'h7B5D, 16'h7B92, 16'h7BC6, 16'h7BF9,
        16'h7C2A, 16'h7C5A, 16'h7C89, 16'h7CB7, 16'h7CE4, 16'h7D0F, 16'h7D3A, 16'h7D63,
        16'h7D8A, 16'h7DB1, 16'h7DD6, 16'h7DFB, 16'h7E1E, 16'h7E3F, 16'h7E60, 16'h7E7F,
        16'h7E9D, 16'h7EBA, 16'h7ED6, 16'h7EF0, 16'h7F0A, 16'h7F22, 16'h7F38, 16'h7F4E,
        16'h7F62, 16'h7F75, 16'h7F87, 16'h7F98, 16'h7FA7, 16'h7FB5, 16'h7FC2, 16'h7FCE,
        16'h7FD9, 16'h7FE2, 16'h7FEA, 16'h7FF1, 16'h7FF6, 16'h7FFA, 16'h7FFE, 16'h7FFF
    };

endpackage

/* src/scl_interp.sv */
// Combinational sine of a 16-bit phase: quarter-wave table lookup, linear
// interpolation between neighboring entries, mirroring and sign. Uses scl_pkg.
module scl_interp (
    input  logic [15:0]        phase,
    output logic signed [15:0] value
);
    import scl_pkg::*;

    logic [7:0]  idx;
    logic [7:0]  hi_idx;
    logic [7:0]  lo_idx;
    logic [6:0]  frac;
    logic [15:0] rom_hi;
    logic [15:0] rom_lo;
    logic [7:0]  diff;
    logic [14:0] prod;
    logic [15:0] rounded;
    logic [15:0] mag;

    assign idx = phase[13:6];

    // In the second quarter the index and the offset run backward.
    always_comb
    begin
        if (phase[14])
        begin
            hi_idx = 8'd0 - idx;
            frac   = OFFSET_SPAN - {1'b0, phase[5:0]};
        end
        else
        begin
            hi_idx = idx + 8'd1;
            frac   = {1'b0, phase[5:0]};
        end
    end

    // The lower neighbor always sits one entry below the upper one.
    assign lo_idx = hi_idx - 8'd1;
    assign rom_hi = QUARTER_ROM[hi_idx];
    assign rom_lo = QUARTER_ROM[lo_idx];

    // Only the low byte of the slope is kept; neighboring entries differ by less.
    assign diff    = rom_hi[7:0] - rom_lo[7:0];
    assign prod    = frac * diff;
    assign rounded = {prod[13:0], 2'b00} + ROUND_BIAS;

    // The peak of the quarter wave lies past the end of the table.
    always_comb
    begin
        if (hi_idx == 8'd0)
        begin
            mag = PEAK_MAG;
        end
        else
        begin
            mag = rom_lo + {8'd0, rounded[15:8]};
        end
    end

    // The second half of the turn negates the magnitude.
    assign value = phase[15] ? $signed(16'd0 - mag) : $signed(mag);

endmodule

/* src/sine_cosine_lut_interp_top.sv */
// Top level of the sine/cosine lookup: request handshakes, input register and
// result register around scl_interp. Uses scl_pkg and scl_interp.
//
// The block takes one angle per cycle while in_ready is high and returns its
// sine or cosine as a signed Q15 value. An accepted request is loaded into
// the input register, and its result then into the result register, where it
// is offered with out_valid. A full turn is 65536 and 0x4000 is 90 degrees;
// func selects sine (0) or cosine (1). The result is in -32767..32767 for
// every angle. There are two register stages: the input register holds the
// phase, and the result register catches the output of the table lookup, the
// 7 by 8 bit interpolation multiply and the sign step. Both stages advance
// whenever the result register is free or being read, so with out_ready held
// high the block sustains one result per cycle; with out_ready low the two
// stages fill up, and then in_ready drops until a result is read.
module sine_cosine_lut_interp_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] angle,
    input  logic               func,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] value
);
    import scl_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [15:0]        phase_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [15:0] value_reg;
    logic signed [15:0] value_calc;
    logic               stage_ready;
    logic               out_load;
    logic               in_load;

    // Each stage may load when it is empty or its contents move on.
    assign stage_ready = !out_valid_reg || out_ready;
    assign in_ready    = !in_valid_reg || stage_ready;
    assign in_load     = in_valid && in_ready;
    assign out_load    = in_valid_reg && stage_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (stage_ready)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    // Valid flags of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register: cosine is the sine a quarter turn later.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            phase_reg <= $unsigned(angle) + (func ? COS_OFFSET : 16'd0);
        end
    end

    scl_interp u_interp (
        .phase (phase_reg),
        .value (value_calc)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            value_reg <= value_calc;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

endmodule
